// ===== rtl/ubpc_pkg.sv =====
// ---------------------------------------------------------------------------
// ubpc_pkg: shared types and constants for the baud prescaler calculator
// Holds the fixed rates, reference clocks, pipeline sizing and the
// restoring division step used by every divider stage.
// ---------------------------------------------------------------------------
package ubpc_pkg;

    localparam int unsigned BAUD_W   = 23;
    localparam int unsigned FACTOR_W = 8;
    localparam int unsigned SEL_W    = 3;

    localparam logic [BAUD_W-1:0]   FIXED_RATE_A = 23'd921600;
    localparam logic [FACTOR_W-1:0] FIXED_CODE_A = 8'hF3;
    localparam logic [BAUD_W-1:0]   FIXED_RATE_B = 23'd307200;
    localparam logic [FACTOR_W-1:0] FIXED_CODE_B = 8'hD9;
    localparam logic [SEL_W-1:0]    SEL_FIXED    = 3'd7;

    localparam int unsigned REF_CLK0 = 11719;
    localparam int unsigned REF_CLK1 = 93750;
    localparam int unsigned REF_CLK2 = 750000;
    localparam int unsigned REF_CLK3 = 6000000;
    localparam int unsigned QUOT_LIMIT = 255;

    localparam logic [BAUD_W-1:0] THRESH1 = 23'(REF_CLK1 / QUOT_LIMIT);
    localparam logic [BAUD_W-1:0] THRESH2 = 23'(REF_CLK2 / QUOT_LIMIT);
    localparam logic [BAUD_W-1:0] THRESH3 = 23'(REF_CLK3 / QUOT_LIMIT);

    localparam logic [SEL_W-1:0] SEL_REF0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_REF1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_REF2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_REF3 = 3'd3;

    localparam logic [FACTOR_W-1:0] QUOT_MAX = 8'd255;

    localparam int unsigned QA_STEPS        = 8;
    localparam int unsigned QB_STEPS        = 23;
    localparam int unsigned TOTAL_STEPS     = QA_STEPS + QB_STEPS;
    localparam int unsigned STEPS_PER_STAGE = 3;
    localparam int unsigned DIV_STAGES      =
        (TOTAL_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int unsigned WIDE_W = 31;

    typedef struct packed {
        logic                done;
        logic                ovf;
        logic                invalid;
        logic [FACTOR_W-1:0] factor;
        logic [SEL_W-1:0]    sel;
        logic [BAUD_W-1:0]   baud;
        logic [BAUD_W-1:0]   rem_a;
        logic [FACTOR_W-1:0] qa;
        logic [BAUD_W-1:0]   rem_b;
        logic [BAUD_W-1:0]   rem_c;
        logic [BAUD_W-1:0]   qb;
        logic [BAUD_W-1:0]   qc;
    } item_t;

    function automatic item_t div_step(item_t it, int unsigned s);
        item_t             r;
        logic [WIDE_W-1:0] ta;
        logic [WIDE_W-1:0] tb;
        logic [WIDE_W-1:0] tc;
        int unsigned       i;
        r  = it;
        ta = '0;
        tb = '0;
        tc = '0;
        i  = 0;
        if (s < QA_STEPS) begin
            i  = QA_STEPS - 1 - s;
            ta = WIDE_W'(it.baud) << i;
            if (WIDE_W'(it.rem_a) >= ta) begin
                r.rem_a = it.rem_a - ta[BAUD_W-1:0];
                r.qa[i[2:0]] = 1'b1;
            end
        end else begin
            i  = TOTAL_STEPS - 1 - s;
            tb = WIDE_W'(it.qa) << i;
            tc = WIDE_W'({1'b0, it.qa} + 9'd1) << i;
            if (WIDE_W'(it.rem_b) >= tb) begin
                r.rem_b = it.rem_b - tb[BAUD_W-1:0];
                r.qb[i[4:0]] = 1'b1;
            end
            if (WIDE_W'(it.rem_c) >= tc) begin
                r.rem_c = it.rem_c - tc[BAUD_W-1:0];
                r.qc[i[4:0]] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/ubpc_div_stage.sv =====
// ---------------------------------------------------------------------------
// ubpc_div_stage: one register stage of the restoring dividers
// Applies a fixed slice of division steps and holds the request on stall.
// ---------------------------------------------------------------------------
module ubpc_div_stage #(
    parameter int unsigned STAGE_IDX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ubpc_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output ubpc_pkg::item_t out_item
);

    logic            valid_reg;
    ubpc_pkg::item_t item_reg;
    ubpc_pkg::item_t item_next;

    always_comb begin
        item_next = in_item;
        for (int unsigned k = 0; k < ubpc_pkg::STEPS_PER_STAGE; k++) begin
            if (STAGE_IDX * ubpc_pkg::STEPS_PER_STAGE + k < ubpc_pkg::TOTAL_STEPS) begin
                item_next = ubpc_pkg::div_step(item_next,
                    STAGE_IDX * ubpc_pkg::STEPS_PER_STAGE + k);
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/ubpc_round.sv =====
// ---------------------------------------------------------------------------
// ubpc_round: final rounding and result register
// Picks the nearer quotient, forms the reload byte and flags bad rates.
// ---------------------------------------------------------------------------
module ubpc_round (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ubpc_pkg::item_t                 in_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ubpc_pkg::FACTOR_W-1:0]   m_factor,
    output logic [ubpc_pkg::SEL_W-1:0]      m_prescale_select,
    output logic                            m_invalid
);

    logic                          valid_reg;
    logic [ubpc_pkg::FACTOR_W-1:0] factor_reg;
    logic [ubpc_pkg::FACTOR_W-1:0] factor_next;
    logic [ubpc_pkg::SEL_W-1:0]    sel_reg;
    logic [ubpc_pkg::SEL_W-1:0]    sel_next;
    logic                          invalid_reg;
    logic                          invalid_next;
    logic [ubpc_pkg::BAUD_W-1:0]   above;
    logic [ubpc_pkg::BAUD_W-1:0]   below;
    logic [ubpc_pkg::FACTOR_W-1:0] q_round;

    always_comb begin
        above   = in_item.qb - in_item.baud;
        below   = in_item.baud - in_item.qc;
        q_round = in_item.qa + ubpc_pkg::FACTOR_W'(above > below);
        if (in_item.done) begin
            factor_next  = in_item.factor;
            sel_next     = in_item.sel;
            invalid_next = in_item.invalid;
        end else if (in_item.ovf || in_item.qa == '0 || in_item.qa == ubpc_pkg::QUOT_MAX) begin
            factor_next  = '0;
            sel_next     = '0;
            invalid_next = 1'b1;
        end else begin
            factor_next  = ubpc_pkg::FACTOR_W'(0) - q_round;
            sel_next     = in_item.sel;
            invalid_next = 1'b0;
        end
    end

    assign in_ready          = !valid_reg || m_ready;
    assign m_valid           = valid_reg;
    assign m_factor          = factor_reg;
    assign m_prescale_select = sel_reg;
    assign m_invalid         = invalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            factor_reg  <= factor_next;
            sel_reg     <= sel_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

// ===== rtl/usb_serial_baud_prescaler_calc_core.sv =====
// ---------------------------------------------------------------------------
// usb_serial_baud_prescaler_calc_core: baud rate to prescaler settings
// Turns a requested line rate into a reload byte and reference selector.
// ---------------------------------------------------------------------------
// Usage:
//   Present a rate on s_baud_request with s_valid; it is taken when s_ready
//   is high. One result per request appears on m_factor, m_prescale_select
//   and m_invalid with m_valid, taken when m_ready is high.
//   The pipeline has one decode stage that picks the reference clock,
//   eleven divider stages (up to three restoring steps each: eight for the
//   quotient, then 23 for the two reciprocal quotients used in rounding)
//   and one rounding stage.
//   Throughput is one request per cycle while m_ready is high; the divider
//   stages are fully pipelined and no request depends on another.
//   Reset clears all stage valid bits; no request is in flight after it.
//   When the receiver stalls, each stage holds its request and the stall
//   propagates back stage by stage to s_ready; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module usb_serial_baud_prescaler_calc_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ubpc_pkg::BAUD_W-1:0]     s_baud_request,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ubpc_pkg::FACTOR_W-1:0]   m_factor,
    output logic [ubpc_pkg::SEL_W-1:0]      m_prescale_select,
    output logic                            m_invalid
);

    localparam int unsigned NS = ubpc_pkg::DIV_STAGES;

    logic                        dec_valid_reg;
    ubpc_pkg::item_t             dec_item_reg;
    ubpc_pkg::item_t             dec_next;
    logic [ubpc_pkg::BAUD_W-1:0] clk_sel;

    logic            st_valid [NS+1];
    logic            st_ready [NS+1];
    ubpc_pkg::item_t st_item  [NS+1];

    always_comb begin
        dec_next      = '0;
        dec_next.baud = s_baud_request;
        if (s_baud_request > ubpc_pkg::THRESH3) begin
            dec_next.sel = ubpc_pkg::SEL_REF3;
            clk_sel      = ubpc_pkg::BAUD_W'(ubpc_pkg::REF_CLK3);
        end else if (s_baud_request > ubpc_pkg::THRESH2) begin
            dec_next.sel = ubpc_pkg::SEL_REF2;
            clk_sel      = ubpc_pkg::BAUD_W'(ubpc_pkg::REF_CLK2);
        end else if (s_baud_request > ubpc_pkg::THRESH1) begin
            dec_next.sel = ubpc_pkg::SEL_REF1;
            clk_sel      = ubpc_pkg::BAUD_W'(ubpc_pkg::REF_CLK1);
        end else begin
            dec_next.sel = ubpc_pkg::SEL_REF0;
            clk_sel      = ubpc_pkg::BAUD_W'(ubpc_pkg::REF_CLK0);
        end
        dec_next.rem_a = clk_sel;
        dec_next.rem_b = clk_sel;
        dec_next.rem_c = clk_sel;
        dec_next.ovf   = ubpc_pkg::WIDE_W'(clk_sel) >= {s_baud_request, 8'd0};
        if (s_baud_request == ubpc_pkg::FIXED_RATE_A) begin
            dec_next.done   = 1'b1;
            dec_next.factor = ubpc_pkg::FIXED_CODE_A;
            dec_next.sel    = ubpc_pkg::SEL_FIXED;
        end else if (s_baud_request == ubpc_pkg::FIXED_RATE_B) begin
            dec_next.done   = 1'b1;
            dec_next.factor = ubpc_pkg::FIXED_CODE_B;
            dec_next.sel    = ubpc_pkg::SEL_FIXED;
        end else if (s_baud_request == '0) begin
            dec_next.done    = 1'b1;
            dec_next.invalid = 1'b1;
            dec_next.sel     = '0;
        end
    end

    assign s_ready     = !dec_valid_reg || st_ready[0];
    assign st_valid[0] = dec_valid_reg;
    assign st_item[0]  = dec_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (s_ready) begin
            dec_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            dec_item_reg <= dec_next;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_div
        ubpc_div_stage #(
            .STAGE_IDX(g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_item   (st_item[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_item  (st_item[g+1])
        );
    end

    ubpc_round u_round (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (st_valid[NS]),
        .in_ready          (st_ready[NS]),
        .in_item           (st_item[NS]),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_factor          (m_factor),
        .m_prescale_select (m_prescale_select),
        .m_invalid         (m_invalid)
    );

endmodule

// ===== rtl/ubpc_checker.sv =====
// ---------------------------------------------------------------------------
// ubpc_checker: port-level checks for the baud prescaler calculator
// Watches the result channel and is bound to the top level.
// ---------------------------------------------------------------------------
module ubpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ubpc_pkg::FACTOR_W-1:0] m_factor,
    input logic [ubpc_pkg::SEL_W-1:0]    m_prescale_select,
    input logic                          m_invalid
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_factor))
        else $error("result dropped while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> m_factor == '0 && m_prescale_select == '0)
        else $error("invalid result carries nonzero fields");

    a_fixed_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_prescale_select == ubpc_pkg::SEL_FIXED |->
            m_factor == ubpc_pkg::FIXED_CODE_A || m_factor == ubpc_pkg::FIXED_CODE_B)
        else $error("fixed selector with unknown code");

    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_invalid |-> m_factor != '0 &&
            (m_prescale_select[2] == 1'b0 || m_prescale_select == ubpc_pkg::SEL_FIXED))
        else $error("valid result out of range");

endmodule

bind usb_serial_baud_prescaler_calc_core ubpc_checker u_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_factor          (m_factor),
    .m_prescale_select (m_prescale_select),
    .m_invalid         (m_invalid)
);
